// File: hw/rtl/dsl_token_lexer_assert.svh
// Assertion macros for the token lexer. Each macro expects clk and rst_n in scope.
`ifndef DSL_TOKEN_LEXER_ASSERT_SVH
`define DSL_TOKEN_LEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSL_LEX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsl_token_lexer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSL_LEX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsl_token_lexer: next-cycle check failed");

`endif

// File: hw/rtl/dsl_lex_pkg.sv
`timescale 1ns / 1ps

package dsl_lex_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int LINE_BITS_DEF     = 16;

  localparam int TOK_LINE_W = 16;
  localparam int TOK_LEN_W  = 8;
  localparam int KW_COUNT   = 12;

  typedef logic [4:0] kind_t;

  localparam kind_t K_EOF    = 5'd0;
  localparam kind_t K_PLUS   = 5'd13;
  localparam kind_t K_MINUS  = 5'd14;
  localparam kind_t K_STAR   = 5'd15;
  localparam kind_t K_SLASH  = 5'd16;
  localparam kind_t K_ASSIGN = 5'd17;
  localparam kind_t K_EQ     = 5'd18;
  localparam kind_t K_NEQ    = 5'd19;
  localparam kind_t K_GT     = 5'd20;
  localparam kind_t K_LT     = 5'd21;
  localparam kind_t K_GTE    = 5'd22;
  localparam kind_t K_LTE    = 5'd23;
  localparam kind_t K_SEMI   = 5'd24;
  localparam kind_t K_COMMA  = 5'd25;
  localparam kind_t K_LPAR   = 5'd26;
  localparam kind_t K_RPAR   = 5'd27;
  localparam kind_t K_IDENT  = 5'd28;
  localparam kind_t K_NUMBER = 5'd29;
  localparam kind_t K_STRING = 5'd30;
  localparam kind_t K_ERROR  = 5'd31;

  // Number recognizer phases.
  localparam logic [1:0] NUM_START  = 2'd0;
  localparam logic [1:0] NUM_ZERO   = 2'd1;
  localparam logic [1:0] NUM_DIGITS = 2'd2;
  localparam logic [1:0] NUM_DEAD   = 2'd3;

  // Keywords packed right-aligned, first character in the most significant used byte.
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_0056_4152,  // VAR
    48'h0000_4C4F_4144,  // LOAD
    48'h4649_4C54_4552,  // FILTER
    48'h0000_004D_4150,  // MAP
    48'h5345_4C45_4354,  // SELECT
    48'h0000_5341_5645,  // SAVE
    48'h0000_0046_4F52,  // FOR
    48'h0057_4849_4C45,  // WHILE
    48'h0000_0000_494E,  // IN
    48'h0000_0000_444F,  // DO
    48'h0000_0045_4E44,  // END
    48'h0000_0000_544F   // TO
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd4, 3'd6, 3'd3, 3'd6, 3'd4, 3'd3, 3'd5, 3'd2, 3'd2, 3'd3, 3'd2
  };

  typedef struct packed {
    kind_t                 kind;
    logic [TOK_LINE_W-1:0] line;
    logic [TOK_LEN_W-1:0]  length;
    logic                  last;
  } tok_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D;
  endfunction

  function automatic logic is_str_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == 8'h5F || c == 8'h20 || c == 8'h2E ||
           c == 8'h2F;
  endfunction

  function automatic logic is_pair_head(input logic [7:0] c);
    return c == 8'h3D || c == 8'h21 || c == 8'h3E || c == 8'h3C;
  endfunction

  // Returns K_EOF when the byte is not a single-character operator.
  function automatic kind_t single_op(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2B: k = K_PLUS;
      8'h2D: k = K_MINUS;
      8'h2A: k = K_STAR;
      8'h2F: k = K_SLASH;
      8'h3B: k = K_SEMI;
      8'h2C: k = K_COMMA;
      8'h28: k = K_LPAR;
      8'h29: k = K_RPAR;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return is_blank(c) || c == 8'h0A || c == 8'h22 || is_pair_head(c) ||
           single_op(c) != K_EOF;
  endfunction

  function automatic logic [1:0] first_phase(input logic [7:0] c);
    logic [1:0] p;
    if (c == 8'h30) begin
      p = NUM_ZERO;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      p = NUM_DIGITS;
    end else begin
      p = NUM_DEAD;
    end
    return p;
  endfunction

  function automatic kind_t single_of_held(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h3D: k = K_ASSIGN;
      8'h3E: k = K_GT;
      8'h3C: k = K_LT;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_of_held(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h3D: k = K_EQ;
      8'h21: k = K_NEQ;
      8'h3E: k = K_GTE;
      default: k = K_LTE;
    endcase
    return k;
  endfunction

  // All twelve keyword compares run side by side; the lowest match wins.
  function automatic kind_t word_kind(input logic [47:0] win, input logic [7:0] len,
                                      input logic ident, input logic [1:0] phase);
    kind_t       k;
    logic [47:0] mask;
    if (ident) begin
      k = K_IDENT;
    end else if (phase == NUM_ZERO || phase == NUM_DIGITS) begin
      k = K_NUMBER;
    end else begin
      k = K_ERROR;
    end
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      mask = ~(48'hFFFF_FFFF_FFFF << (8 * KW_LEN[i]));
      if (len == 8'(KW_LEN[i]) && (win & mask) == KW_TEXT[i]) begin
        k = kind_t'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/dsl_token_lexer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Beat contents
// in_       input      in_valid/in_stall  in_char_in, in_end_of_input
// out_      output     out_valid/out_stall out_token_kind, out_token_line,
//                                         out_token_length, out_last
//
// A character beat is registered, then lexed against the lexer state;
// its zero, one or two tokens go into a four-entry result queue.
// One character per cycle is taken while the queue has room; the input stalls when
// the queue holds more than two. An input beat passes the input register and then
// the result queue before its first token is offered at the output.
// Synchronous active-low reset returns the lexer to idle at line 1 and empties the queue.
// out_stall only holds the queue head; in_stall is a function of registers alone.

module dsl_token_lexer
  import dsl_lex_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_in,
  input  logic                  in_end_of_input,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kind_t                 out_token_kind,
  output logic [TOK_LINE_W-1:0] out_token_line,
  output logic [TOK_LEN_W-1:0]  out_token_length,
  output logic                  out_last
);

  localparam int RUN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int QD    = 4;
  localparam int QP_W  = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_OP   = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;
  localparam logic [1:0] MODE_STR  = 2'd3;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [RUN_W-1:0]     RUN_MAX  = RUN_W'(MAX_TOKEN_LEN);
  localparam logic [RUN_W-1:0]     RUN_ONE  = RUN_W'(1);

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eoi_r;

  // Lexer state
  logic [1:0]           mode_r, mode_nxt;
  logic [7:0]           held_r, held_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic                 ident_r, ident_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic                 str_ok_r, str_ok_nxt;
  logic [47:0]          win_r, win_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [LINE_BITS-1:0] start_r, start_nxt;

  // Result queue
  tok_t            q_r [QD];
  logic [QP_W-1:0] wr_r, rd_r;
  logic [QC_W-1:0] cnt_r;

  logic            room;
  logic            proc;
  logic            pop;
  logic [1:0]      push_n;

  logic [7:0]       c;
  logic [RUN_W-1:0] w_run;
  logic             w_ident;
  logic [1:0]       w_phase;
  logic [47:0]      w_win;
  logic [RUN_W-1:0] s_run;

  logic                 a_v;
  kind_t                a_kind;
  logic [RUN_W-1:0]     a_len;
  logic                 f_v;
  kind_t                f_kind;
  logic [RUN_W-1:0]     f_len;
  logic                 do_fresh;
  kind_t                fresh_op;

  tok_t tok_a, tok_f, res0, res1;
  logic res0_v, res1_v;

  assign room     = cnt_r <= QC_W'(QD - 2);
  assign in_stall = s1_valid_r && !room;
  assign proc     = s1_valid_r && room;
  assign pop      = out_valid && !out_stall;

  assign c = s1_char_r;

  // Values after appending the current byte to the word in progress.
  assign w_run   = run_r + RUN_ONE;
  assign w_ident = ident_r && (is_letter(c) || is_digit(c) || c == 8'h5F);
  assign w_win   = {win_r[39:0], c};
  assign s_run   = run_r + RUN_ONE;
  assign fresh_op = single_op(c);

  always_comb begin
    case (phase_r)
      NUM_START:  w_phase = first_phase(c);
      NUM_DIGITS: w_phase = is_digit(c) ? NUM_DIGITS : NUM_DEAD;
      default:    w_phase = NUM_DEAD;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    run_nxt    = run_r;
    ident_nxt  = ident_r;
    phase_nxt  = phase_r;
    str_ok_nxt = str_ok_r;
    win_nxt    = win_r;
    line_nxt   = line_r;
    start_nxt  = start_r;
    a_v        = 1'b0;
    a_kind     = K_ERROR;
    a_len      = run_r;
    f_v        = 1'b0;
    f_kind     = K_EOF;
    f_len      = '0;
    do_fresh   = 1'b0;

    if (proc) begin
      if (s1_eoi_r) begin
        case (mode_r)
          MODE_OP: begin
            a_v    = 1'b1;
            a_kind = single_of_held(held_r);
            a_len  = RUN_ONE;
          end
          MODE_WORD: begin
            a_v    = 1'b1;
            a_kind = word_kind(win_r, 8'(run_r), ident_r, phase_r);
          end
          MODE_STR: begin
            a_v = 1'b1;
          end
          default: begin
            a_v = 1'b0;
          end
        endcase
        mode_nxt = MODE_IDLE;
        f_v      = 1'b1;
      end else begin
        case (mode_r)
          MODE_OP: begin
            mode_nxt = MODE_IDLE;
            a_v      = 1'b1;
            if (c == 8'h3D) begin
              a_kind = pair_of_held(held_r);
              a_len  = RUN_W'(2);
            end else begin
              a_kind   = single_of_held(held_r);
              a_len    = RUN_ONE;
              do_fresh = 1'b1;
            end
          end
          MODE_WORD: begin
            if (!ends_word(c)) begin
              run_nxt   = w_run;
              ident_nxt = w_ident;
              phase_nxt = w_phase;
              win_nxt   = w_win;
              if (w_run >= RUN_MAX) begin
                a_v      = 1'b1;
                a_kind   = word_kind(w_win, 8'(w_run), w_ident, w_phase);
                a_len    = w_run;
                mode_nxt = MODE_IDLE;
              end
            end else begin
              a_v      = 1'b1;
              a_kind   = word_kind(win_r, 8'(run_r), ident_r, phase_r);
              mode_nxt = MODE_IDLE;
              do_fresh = 1'b1;
            end
          end
          MODE_STR: begin
            run_nxt = s_run;
            a_len   = s_run;
            if (c == 8'h22) begin
              a_v      = 1'b1;
              a_kind   = str_ok_r ? K_STRING : K_ERROR;
              mode_nxt = MODE_IDLE;
            end else begin
              if (!is_str_char(c)) begin
                str_ok_nxt = 1'b0;
              end
              // An overlong string is cut here without consuming another byte.
              if (s_run >= RUN_MAX) begin
                a_v      = 1'b1;
                mode_nxt = MODE_IDLE;
              end
            end
          end
          default: begin
            do_fresh = 1'b1;
          end
        endcase
      end

      if (do_fresh) begin
        if (c == 8'h0A) begin
          if (line_r != '1) begin
            line_nxt = line_r + LINE_ONE;
          end
        end else if (!is_blank(c)) begin
          start_nxt = line_r;
          if (c == 8'h22) begin
            mode_nxt   = MODE_STR;
            run_nxt    = RUN_ONE;
            str_ok_nxt = 1'b1;
          end else if (is_pair_head(c)) begin
            mode_nxt = MODE_OP;
            held_nxt = c;
          end else if (fresh_op != K_EOF) begin
            f_v    = 1'b1;
            f_kind = fresh_op;
            f_len  = RUN_ONE;
          end else begin
            // The cut length is at least eight, so a one-byte word never ends here.
            mode_nxt  = MODE_WORD;
            run_nxt   = RUN_ONE;
            ident_nxt = is_letter(c);
            phase_nxt = first_phase(c);
            win_nxt   = {40'd0, c};
          end
        end
      end
    end
  end

  always_comb begin
    tok_a.kind   = a_kind;
    tok_a.line   = TOK_LINE_W'(start_r);
    tok_a.length = TOK_LEN_W'(a_len);
    tok_a.last   = !f_v;
    tok_f.kind   = f_kind;
    tok_f.line   = TOK_LINE_W'(line_r);
    tok_f.length = TOK_LEN_W'(f_len);
    tok_f.last   = 1'b1;
    if (a_v) begin
      res0   = tok_a;
      res0_v = 1'b1;
      res1   = tok_f;
      res1_v = f_v;
    end else begin
      res0   = tok_f;
      res0_v = f_v;
      res1   = tok_f;
      res1_v = 1'b0;
    end
    push_n = {1'b0, res0_v} + {1'b0, res1_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r     <= MODE_IDLE;
      held_r     <= '0;
      run_r      <= '0;
      ident_r    <= 1'b0;
      phase_r    <= NUM_START;
      str_ok_r   <= 1'b0;
      win_r      <= '0;
      line_r     <= LINE_ONE;
      start_r    <= LINE_ONE;
      wr_r       <= '0;
      rd_r       <= '0;
      cnt_r      <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      run_r    <= run_nxt;
      ident_r  <= ident_nxt;
      phase_r  <= phase_nxt;
      str_ok_r <= str_ok_nxt;
      win_r    <= win_nxt;
      line_r   <= line_nxt;
      start_r  <= start_nxt;
      wr_r     <= wr_r + QP_W'(push_n);
      rd_r     <= rd_r + QP_W'(pop);
      cnt_r    <= cnt_r + QC_W'(push_n) - QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_in;
      s1_eoi_r  <= in_end_of_input;
    end
    if (res0_v) begin
      q_r[wr_r] <= res0;
    end
    if (res1_v) begin
      q_r[wr_r + QP_W'(1)] <= res1;
    end
  end

  assign out_valid        = cnt_r != '0;
  assign out_token_kind   = q_r[rd_r].kind;
  assign out_token_line   = q_r[rd_r].line;
  assign out_token_length = q_r[rd_r].length;
  assign out_last         = q_r[rd_r].last;

`include "dsl_token_lexer_assert.svh"

  `DSL_LEX_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r <= QC_W'(QD))
  `DSL_LEX_ASSERT_NOW(a_eof_is_last, out_valid && out_token_kind == K_EOF, out_last)
  `DSL_LEX_ASSERT_NEXT(a_eoi_to_idle, proc && s1_eoi_r, mode_r == MODE_IDLE)
  `DSL_LEX_ASSERT_NOW(a_line_nonzero, 1'b1, line_r != '0)

endmodule

// File: test/tb_dsl_token_lexer.sv
`timescale 1ns / 1ps

module tb_dsl_token_lexer
  import dsl_lex_pkg::*;
();

  localparam int RANDOM_BEATS = 1820;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 5000;

  class token_tracker;
    typedef enum logic [1:0] {LX_IDLE, LX_OP, LX_WORD, LX_STR} lex_state_t;

    tok_t        expected_tokens[$];
    int          mismatches;
    int          checked;
    lex_state_t  state;
    logic [7:0]  held;
    int          run_len;
    bit          ident_ok;
    bit          str_ok;
    logic [1:0]  num_phase;
    logic [47:0] window;
    int          line_no;
    int          tok_line;

    function new();
      state      = LX_IDLE;
      held       = 8'h00;
      run_len    = 0;
      ident_ok   = 1'b0;
      str_ok     = 1'b0;
      num_phase  = NUM_START;
      window     = '0;
      line_no    = 1;
      tok_line   = 1;
      mismatches = 0;
      checked    = 0;
    endfunction

    static function string keyword_text(int i);
      case (i)
        0: return "VAR";
        1: return "LOAD";
        2: return "FILTER";
        3: return "MAP";
        4: return "SELECT";
        5: return "SAVE";
        6: return "FOR";
        7: return "WHILE";
        8: return "IN";
        9: return "DO";
        10: return "END";
        default: return "TO";
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit in_string_set(logic [7:0] c);
      return is_alpha(c) || is_num(c) || c == "_" || c == " " || c == "." || c == "/";
    endfunction

    function kind_t plain_op(logic [7:0] c);
      case (c)
        "+": return K_PLUS;
        "-": return K_MINUS;
        "*": return K_STAR;
        "/": return K_SLASH;
        ";": return K_SEMI;
        ",": return K_COMMA;
        "(": return K_LPAR;
        ")": return K_RPAR;
        default: return K_EOF;
      endcase
    endfunction

    function bit opens_pair(logic [7:0] c);
      return c == "=" || c == "!" || c == ">" || c == "<";
    endfunction

    function bit breaks_word(logic [7:0] c);
      return c == " " || c == "\t" || c == 8'h0D || c == "\n" || c == "\"" ||
             opens_pair(c) || plain_op(c) != K_EOF;
    endfunction

    function kind_t held_single();
      case (held)
        "=": return K_ASSIGN;
        ">": return K_GT;
        "<": return K_LT;
        default: return K_ERROR;
      endcase
    endfunction

    function kind_t held_pair();
      case (held)
        "=": return K_EQ;
        "!": return K_NEQ;
        ">": return K_GTE;
        default: return K_LTE;
      endcase
    endfunction

    function kind_t word_class();
      logic [63:0] kw_bits;
      logic [63:0] mask;
      string       k;
      for (int i = 0; i < KW_COUNT; i++) begin
        k = keyword_text(i);
        if (run_len == k.len()) begin
          kw_bits = '0;
          for (int j = 0; j < k.len(); j++) begin
            kw_bits = (kw_bits << 8) | 64'(k[j]);
          end
          mask = (64'd1 << (8 * k.len())) - 64'd1;
          if (({16'd0, window} & mask) == kw_bits) begin
            return kind_t'(i + 1);
          end
        end
      end
      if (ident_ok) begin
        return K_IDENT;
      end
      if (num_phase == NUM_ZERO || num_phase == NUM_DIGITS) begin
        return K_NUMBER;
      end
      return K_ERROR;
    endfunction

    function void add_token(kind_t k, int ln, int len);
      tok_t t;
      t.kind   = k;
      t.line   = 16'(ln);
      t.length = 8'(len);
      t.last   = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function void absorb(logic [7:0] c);
      if (run_len == 0) begin
        ident_ok = is_alpha(c);
      end else if (!(is_alpha(c) || is_num(c) || c == "_")) begin
        ident_ok = 1'b0;
      end
      case (num_phase)
        NUM_START: begin
          if (c == "0") begin
            num_phase = NUM_ZERO;
          end else if (c >= "1" && c <= "9") begin
            num_phase = NUM_DIGITS;
          end else begin
            num_phase = NUM_DEAD;
          end
        end
        NUM_DIGITS: num_phase = is_num(c) ? NUM_DIGITS : NUM_DEAD;
        default: num_phase = NUM_DEAD;
      endcase
      window = {window[39:0], c};
      run_len++;
    endfunction

    // A word that hits the length limit goes out at once.
    function void cut_if_full();
      if (run_len >= MAX_TOKEN_LEN_DEF) begin
        add_token(word_class(), tok_line, run_len);
        state = LX_IDLE;
      end
    endfunction

    function void start_fresh(logic [7:0] c);
      kind_t k;
      if (c == "\n") begin
        if (line_no < (1 << LINE_BITS_DEF) - 1) begin
          line_no++;
        end
        return;
      end
      if (c == " " || c == "\t" || c == 8'h0D) begin
        return;
      end
      tok_line = line_no;
      if (c == "\"") begin
        state   = LX_STR;
        run_len = 1;
        str_ok  = 1'b1;
        return;
      end
      if (opens_pair(c)) begin
        state = LX_OP;
        held  = c;
        return;
      end
      k = plain_op(c);
      if (k != K_EOF) begin
        add_token(k, tok_line, 1);
        return;
      end
      state     = LX_WORD;
      run_len   = 0;
      ident_ok  = 1'b0;
      num_phase = NUM_START;
      window    = '0;
      absorb(c);
      cut_if_full();
    endfunction

    function void note_char(logic [7:0] c, logic eoi);
      int   first;
      tok_t t;
      first = expected_tokens.size();
      if (eoi) begin
        case (state)
          LX_OP: add_token(held_single(), tok_line, 1);
          LX_WORD: add_token(word_class(), tok_line, run_len);
          LX_STR: add_token(K_ERROR, tok_line, run_len);
          default: ;
        endcase
        state = LX_IDLE;
        add_token(K_EOF, line_no, 0);
      end else begin
        case (state)
          LX_OP: begin
            state = LX_IDLE;
            if (c == "=") begin
              add_token(held_pair(), tok_line, 2);
            end else begin
              add_token(held_single(), tok_line, 1);
              start_fresh(c);
            end
          end
          LX_WORD: begin
            if (!breaks_word(c)) begin
              absorb(c);
              cut_if_full();
            end else begin
              add_token(word_class(), tok_line, run_len);
              state = LX_IDLE;
              start_fresh(c);
            end
          end
          LX_STR: begin
            run_len++;
            if (c == "\"") begin
              add_token(str_ok ? K_STRING : K_ERROR, tok_line, run_len);
              state = LX_IDLE;
            end else begin
              if (!in_string_set(c)) begin
                str_ok = 1'b0;
              end
              // An overlong string is reported as error without eating a byte.
              if (run_len >= MAX_TOKEN_LEN_DEF) begin
                add_token(K_ERROR, tok_line, run_len);
                state = LX_IDLE;
              end
            end
          end
          default: start_fresh(c);
        endcase
      end
      if (expected_tokens.size() > first) begin
        t = expected_tokens.pop_back();
        t.last = 1'b1;
        expected_tokens.push_back(t);
      end
    endfunction

    task check_token(kind_t k, logic [15:0] ln, logic [7:0] len, logic lst);
      tok_t want;
      checked++;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d line %0d length %0d last %0b",
                                  k, ln, len, lst));
        return;
      end
      want = expected_tokens.pop_front();
      if (want.kind !== k || want.line !== ln || want.length !== len || want.last !== lst) begin
        report_mismatch($sformatf(
          "token %0d: got kind %0d line %0d length %0d last %0b, want %0d %0d %0d %0b",
          checked, k, ln, len, lst, want.kind, want.line, want.length, want.last));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char_in = 8'h00;
  logic                  in_end_of_input = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kind_t                 out_token_kind;
  logic [TOK_LINE_W-1:0] out_token_line;
  logic [TOK_LEN_W-1:0]  out_token_length;
  logic                  out_last;

  token_tracker tracker = new();
  int           send_calm = 0;
  int           recv_calm = 0;
  int           beats_sent = 0;

  dsl_token_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) begin
      return rand_letter();
    end
    if (r < 62) begin
      return 8'(8'h30 + r - 52);
    end
    return "_";
  endfunction

  function automatic logic [7:0] rand_str_char();
    case ($urandom_range(0, 9))
      0: return " ";
      1: return ".";
      2: return "/";
      default: return rand_word_char();
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return "\t";
      2: return 8'h0D;
      default: return "\n";
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic eoi);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_char_in      <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    tracker.note_char(c, eoi);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0);
    end
  endtask

  task automatic send_long_token(input bit quoted);
    int n;
    n = $urandom_range(250, 260);
    if (quoted) begin
      send_beat("\"", 1'b0);
    end
    for (int i = 0; i < n; i++) begin
      if (quoted) begin
        send_beat(rand_str_char(), 1'b0);
      end else begin
        send_beat((i == 0) ? rand_letter() : rand_word_char(), 1'b0);
      end
    end
    if (quoted) begin
      send_beat("\"", 1'b0);
    end
  endtask

  task automatic send_random_token();
    int         pick;
    int         n;
    int         r;
    logic [7:0] c;
    string      ops;
    ops  = "+-*/;,()=!><";
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_text(token_tracker::keyword_text($urandom_range(0, KW_COUNT - 1)));
      if ($urandom_range(0, 4) == 0) begin
        send_beat(rand_word_char(), 1'b0);
      end
    end else if (pick < 33) begin
      send_beat(rand_letter(), 1'b0);
      repeat ($urandom_range(0, 10)) send_beat(rand_word_char(), 1'b0);
    end else if (pick < 45) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat("0", 1'b0);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      end else begin
        send_beat(8'(8'h31 + $urandom_range(0, 8)), 1'b0);
        n = $urandom_range(0, 7);
      end
      repeat (n) send_beat(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 9) == 0) begin
        send_beat(rand_letter(), 1'b0);
      end
    end else if (pick < 55) begin
      send_beat("\"", 1'b0);
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 19) == 0) begin
          c = $urandom_range(0, 1) ? 8'h0A : 8'($urandom_range(0, 255));
        end else begin
          c = rand_str_char();
        end
        send_beat(c, 1'b0);
      end
      if ($urandom_range(0, 29) != 0) begin
        send_beat("\"", 1'b0);
      end
    end else if (pick < 75) begin
      r = $urandom_range(0, 11);
      send_beat(ops[r], 1'b0);
      if (r >= 8 && $urandom_range(0, 1) == 1) begin
        send_beat("=", 1'b0);
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 3)) send_beat(rand_blank(), 1'b0);
    end else if (pick < 93) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 96) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_beat(rand_letter(), 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b0);
      send_beat(rand_word_char(), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_token(out_token_kind, out_token_line, out_token_length, out_last);
    end
  end

  // Result side: random stall bursts, plus one long hold-off while the sender keeps going.
  initial begin
    int hold;
    bit long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!long_hold_done && tracker.checked >= 150) begin
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold = pick_gap(recv_calm);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int tok_no;
    int pause_at;
    int long_word_at;
    int long_str_at;
    int drain;
    pause_at     = $urandom_range(100, 250);
    long_word_at = $urandom_range(10, 200);
    long_str_at  = $urandom_range(10, 200);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every operator pairing, a lone bang, a keyword cut by a quote, then a string
    // holding a newline and a high byte, a NUL word and end of input.
    send_text("=>=<=!=<>!(==)+-*/;,TO\"a");
    send_beat("\n", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("\"", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);

    tok_no = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (tok_no == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.expected_tokens.size() != 0);
      end
      if (tok_no == long_word_at) begin
        send_long_token(1'b0);
      end else if (tok_no == long_str_at + 1) begin
        send_long_token(1'b1);
      end else begin
        send_random_token();
      end
      if ($urandom_range(0, 9) < 6) begin
        send_beat(rand_blank(), 1'b0);
      end
      tok_no++;
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    drain = 0;
    while (tracker.expected_tokens.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (tracker.expected_tokens.size() != 0) begin
      tracker.report_mismatch($sformatf("%0d expected tokens never arrived",
                                        tracker.expected_tokens.size()));
    end
    if (tracker.mismatches == 0) begin
      $display("** dsl_token_lexer: PASSED **");
    end else begin
      $display("** dsl_token_lexer: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** dsl_token_lexer: FAILED **");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dsl_lex_pkg.sv
hw/rtl/dsl_token_lexer.sv
test/tb_dsl_token_lexer.sv
